/* hdl/maze_junction_explorer_defines.svh */
`ifndef MAZE_JUNCTION_EXPLORER_DEFINES_SVH
`define MAZE_JUNCTION_EXPLORER_DEFINES_SVH

// same-cycle implication
`define MJE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MJE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/mje_pkg.sv */
package mje_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LW = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		logic [3:0] taken;
		logic [3:0] branches;
		logic [7:0] number;
	} entry_t;

	typedef struct packed {
		logic [3:0] choice;
		logic       done;
		logic [7:0] node;
		logic       known;
		logic       ovf;
	} res_t;

	localparam res_t RES_DONE = '{4'd0, 1'b1, 8'd0, 1'b0, 1'b0};

endpackage

/* hdl/maze_junction_explorer.sv */
// Depth-first maze exploration stack.
// Input channel (item_valid/item_ready) carries one junction report:
// branch_count and backtrack. Output channel (res_valid/res_ready) returns
// exactly one result per report: branch_choice, done_res, node_number,
// node_known and stack_overflow.
// One report is handled at a time; item_ready is high only while the
// sequencer is idle, including while a previous result still waits.
// Steps from the accepting edge until the result is loaded for output:
//   new junction push, dead end after U-turn, empty stack, finished: final step
//   backtrack pop: stack read, top-of-stack step, final step
//   U-turn advance: stack read, top-of-stack step, one trial subtraction per
//   cycle of the shared 5-bit subtractor for the modulo by branch count,
//   then the final step
//   dead end: one stack entry read per cycle from the single-read-port stack
//   memory for the exhausted check, then the final step
// Reset clears the stack level, the U-turn and finished flags and sets the
// node counter to one; stack contents need no clearing.
// When the receiver stalls the result is held in the output register and
// the sequencer waits in its final step until that register is free.
module maze_junction_explorer
	import mje_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [3:0] branch_count,
	input  logic       backtrack,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [3:0] branch_choice,
	output logic       done_res,
	output logic [7:0] node_number,
	output logic       node_known,
	output logic       stack_overflow
);

`include "maze_junction_explorer_defines.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_TOP  = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]    state_q;
	logic [3:0]    n_q;
	logic          bt_q;
	logic [LW-1:0] level_q;
	logic          uturn_q;
	logic          edone_q;
	logic [7:0]    next_q;
	logic [LW-1:0] scan_q;
	logic          chk_q;
	logic [4:0]    rem_q;
	res_t          res_q;
	res_t          out_q;
	logic          res_valid_q;

	entry_t        mem [STACK_DEPTH];
	entry_t        mem_rd_q;

	logic [LW-1:0] level_m1;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wa;
	entry_t        wd;
	logic [4:0]    opa;
	logic [4:0]    opb;
	logic [4:0]    diff;
	logic          accept;
	logic          multi;
	logic          full;
	logic          scan_miss;
	logic          load_out;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign multi      = (branch_count > 4'd1);
	assign full       = (level_q >= LW'(STACK_DEPTH));
	assign level_m1   = level_q - LW'(1);
	assign scan_miss  = chk_q && (mem_rd_q.taken != (mem_rd_q.branches - 4'd1));
	assign load_out   = (state_q == S_FIN) && (!res_valid_q || res_ready);

	assign res_valid      = res_valid_q;
	assign branch_choice  = out_q.choice;
	assign done_res       = out_q.done;
	assign node_number    = out_q.node;
	assign node_known     = out_q.known;
	assign stack_overflow = out_q.ovf;

	always_comb begin
		rd_addr = (state_q == S_SCAN) ? scan_q[AW-1:0] : level_m1[AW-1:0];
		if (state_q == S_MOD) begin
			opa = rem_q;
			opb = {1'b0, n_q};
		end else begin
			opa = {1'b0, mem_rd_q.branches};
			opb = {1'b0, mem_rd_q.taken};
		end
		diff = opa - opb;
		we = 1'b0;
		wa = level_q[AW-1:0];
		wd = '{4'd1, branch_count, next_q};
		if (accept && !edone_q && !backtrack && multi && !uturn_q && !full) begin
			we = 1'b1;
		end else if (state_q == S_MOD && diff[4] && rem_q[3:0] != 4'd0) begin
			we = 1'b1;
			wa = level_m1[AW-1:0];
			wd = '{rem_q[3:0], mem_rd_q.branches, mem_rd_q.number};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= '0;
			uturn_q     <= 1'b0;
			edone_q     <= 1'b0;
			next_q      <= 8'd1;
			scan_q      <= '0;
			chk_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q  <= branch_count;
						bt_q <= backtrack;
						if (edone_q) begin
							res_q   <= RES_DONE;
							state_q <= S_FIN;
						end else if (backtrack || (multi && uturn_q)) begin
							if (level_q == '0) begin
								edone_q <= 1'b1;
								res_q   <= RES_DONE;
								state_q <= S_FIN;
							end else begin
								state_q <= S_RD;
							end
						end else if (uturn_q) begin
							uturn_q <= 1'b0;
							res_q   <= '{4'd1, 1'b0, 8'd0, 1'b0, 1'b0};
							if (level_q == '0) begin
								edone_q <= 1'b1;
							end
							state_q <= S_FIN;
						end else if (!multi) begin
							uturn_q <= 1'b1;
							if (level_q == '0) begin
								res_q   <= RES_DONE;
								state_q <= S_FIN;
							end else begin
								scan_q  <= '0;
								chk_q   <= 1'b0;
								state_q <= S_SCAN;
							end
						end else begin
							res_q <= '{4'd1, 1'b0, next_q, 1'b0, full};
							if (!full) begin
								level_q <= level_q + LW'(1);
							end
							next_q  <= next_q + 8'd1;
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					chk_q <= (scan_q < level_q);
					if (scan_q < level_q) begin
						scan_q <= scan_q + LW'(1);
					end
					if (scan_miss) begin
						res_q   <= '{4'd1, 1'b0, next_q, 1'b0, 1'b0};
						next_q  <= next_q + 8'd1;
						state_q <= S_FIN;
					end else if (!chk_q && scan_q == level_q) begin
						res_q   <= RES_DONE;
						state_q <= S_FIN;
					end
				end
				S_RD: begin
					state_q <= S_TOP;
				end
				S_TOP: begin
					if (bt_q) begin
						res_q   <= '{diff[3:0], 1'b0, mem_rd_q.number, 1'b1, 1'b0};
						level_q <= level_m1;
						if (level_m1 == '0) begin
							edone_q <= 1'b1;
						end
						state_q <= S_FIN;
					end else begin
						rem_q   <= {1'b0, mem_rd_q.taken} + 5'd1;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!diff[4]) begin
						rem_q <= diff;
					end else begin
						res_q <= '{4'd1, 1'b0, mem_rd_q.number, 1'b1, 1'b0};
						if (rem_q[3:0] != 4'd0) begin
							uturn_q <= 1'b0;
						end else begin
							level_q <= level_m1;
							if (level_m1 == '0) begin
								edone_q <= 1'b1;
							end
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MJE_ASSERT_NOW(a_level_bound, 1'b1, level_q <= LW'(STACK_DEPTH))
	`MJE_ASSERT_NOW(a_done_clean, res_valid && done_res,
		branch_choice == 4'd0 && node_number == 8'd0 && !node_known && !stack_overflow)
	`MJE_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)
	`MJE_ASSERT_NEXT(a_done_sticky, edone_q, edone_q)

endmodule
